/* rtl/core/dbd_pkg.sv */
// Shared types, constants and tables for the day difference core.
`default_nettype none

package dbd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int DIFF_W   = 23;
  localparam int SERIAL_W = 23;
  localparam int DOY_W    = 9;
  localparam int LEAPS_W  = 13;
  localparam int QUOT_W   = 8;
  localparam int MUL_A_W  = 13;
  localparam int RECIP_W  = 11;
  localparam int PROD_W   = MUL_A_W + RECIP_W;

  localparam int IN_BYTES  = (2 * (YEAR_W + MONTH_W + DAY_W) + 7) / 8;
  localparam int OUT_BYTES = (DIFF_W + 7) / 8;
  localparam int IN_TDATA_W  = IN_BYTES * 8;
  localparam int OUT_TDATA_W = OUT_BYTES * 8;

  // floor(t / 25) == (t * 1311) >> 15 for t below 4200
  localparam logic [RECIP_W-1:0] DIV25_RECIP = 11'd1311;
  localparam int                 DIV25_SHIFT = 15;

  localparam logic signed [DIFF_W:0] DIFF_LIMIT = 24'sd4000000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIV100,
    OP_DIV400,
    OP_PARTS,
    OP_SERIAL,
    OP_DIFF
  } dbd_op_t;

  typedef struct packed {
    logic    load;
    dbd_op_t op;
    logic    sel;
  } dbd_cmd_t;

  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] r;
    begin
      unique case (idx)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd59;
        4'd3:    r = 9'd90;
        4'd4:    r = 9'd120;
        4'd5:    r = 9'd151;
        4'd6:    r = 9'd181;
        4'd7:    r = 9'd212;
        4'd8:    r = 9'd243;
        4'd9:    r = 9'd273;
        4'd10:   r = 9'd304;
        default: r = 9'd334;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dbd_ctrl.sv */
// Sequencer for the day difference core: steps both dates through the datapath.
`default_nettype none

module dbd_ctrl
  import dbd_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  output dbd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV100,
    S_DIV400,
    S_PARTS,
    S_SERIAL,
    S_DIFF
  } state_t;

  state_t state;
  logic   sel;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    cmd.sel  = sel;
    unique case (state)
      S_IDLE:   cmd.load = in_valid;
      S_DIV100: cmd.op   = OP_DIV100;
      S_DIV400: cmd.op   = OP_DIV400;
      S_PARTS:  cmd.op   = OP_PARTS;
      S_SERIAL: cmd.op   = OP_SERIAL;
      S_DIFF:   cmd.op   = out_free ? OP_DIFF : OP_NONE;
      default:  cmd.op   = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DIFF)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sel   <= 1'b0;
            state <= S_DIV100;
          end
        end
        S_DIV100: state <= S_DIV400;
        S_DIV400: state <= S_PARTS;
        S_PARTS:  state <= S_SERIAL;
        S_SERIAL: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_DIV100;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/dbd_datapath.sv */
// Datapath: date latch, shared reciprocal divider, serial day sums and difference.
`default_nettype none

module dbd_datapath
  import dbd_pkg::*;
(
  input  wire                    clk,
  input  wire  [IN_TDATA_W-1:0]  in_data,
  input  dbd_cmd_t               cmd,
  output logic [DIFF_W-1:0]      day_difference
);

  logic [YEAR_W-1:0]  first_year, second_year;
  logic [MONTH_W-1:0] first_month, second_month;
  logic [DAY_W-1:0]   first_day, second_day;

  logic [QUOT_W-1:0]   q100, q400;
  logic [LEAPS_W-1:0]  leaps;
  logic [DOY_W-1:0]    doy;
  logic [SERIAL_W-1:0] serial_a, serial_b;

  logic [YEAR_W-1:0]  y;
  logic [MONTH_W-1:0] m, m_idx;
  logic [DAY_W-1:0]   d;
  logic [YEAR_W:0]    y_p99, y_p399, y_p3;
  logic [MUL_A_W-1:0] mul_a;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  logic [YEAR_W:0]    q100_x100;
  logic [YEAR_W+2:0]  q400_x400;
  logic               leap;
  logic [LEAPS_W-1:0] leaps_next;
  logic [DOY_W-1:0]   doy_next;
  logic [SERIAL_W-1:0] serial_next;
  logic signed [DIFF_W:0] diff, diff_sat;

  assign y = cmd.sel ? second_year  : first_year;
  assign m = cmd.sel ? second_month : first_month;
  assign d = cmd.sel ? second_day   : first_day;

  // ceil(y/100) and ceil(y/400) through one multiplier by 1/25
  assign y_p99  = {1'b0, y} + 15'd99;
  assign y_p399 = {1'b0, y} + 15'd399;
  assign y_p3   = {1'b0, y} + 15'd3;
  assign mul_a  = (cmd.op == OP_DIV400) ? {2'b0, y_p399[YEAR_W:4]} : y_p99[YEAR_W:2];
  assign prod   = {{RECIP_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, DIV25_RECIP};
  assign quot   = prod[DIV25_SHIFT +: QUOT_W];

  // y divisible by 100 (400) exactly when ceil quotient times divisor equals y
  assign q100_x100 = 15'(q100 * 15'd100);
  assign q400_x400 = 17'(q400 * 17'd400);
  assign leap = ((y[1:0] == 2'b00) && (q100_x100 != {1'b0, y})) ||
                (q400_x400 == {3'b0, y});

  always_comb begin
    if (m == 4'd0) begin
      m_idx = 4'd0;
    end else if (m > 4'd12) begin
      m_idx = 4'd11;
    end else begin
      m_idx = m - 4'd1;
    end
  end

  assign leaps_next  = y_p3[YEAR_W:2] - {5'b0, q100} + {5'b0, q400};
  assign doy_next    = {4'b0, d} + days_before_month(m_idx) +
                       {8'b0, (m_idx > 4'd1) && leap};
  assign serial_next = SERIAL_W'(y * 23'd365) + {10'b0, leaps} + {14'b0, doy};

  assign diff = $signed({1'b0, serial_b}) - $signed({1'b0, serial_a});

  always_comb begin
    if (diff > DIFF_LIMIT) begin
      diff_sat = DIFF_LIMIT;
    end else if (diff < -DIFF_LIMIT) begin
      diff_sat = -DIFF_LIMIT;
    end else begin
      diff_sat = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_year   <= in_data[13:0];
      first_month  <= in_data[17:14];
      first_day    <= in_data[22:18];
      second_year  <= in_data[36:23];
      second_month <= in_data[40:37];
      second_day   <= in_data[45:41];
    end
    unique case (cmd.op)
      OP_DIV100: q100 <= quot;
      OP_DIV400: q400 <= quot;
      OP_PARTS: begin
        leaps <= leaps_next;
        doy   <= doy_next;
      end
      OP_SERIAL: begin
        if (cmd.sel) begin
          serial_b <= serial_next;
        end else begin
          serial_a <= serial_next;
        end
      end
      OP_DIFF: day_difference <= diff_sat[DIFF_W-1:0];
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/days_between_dates_core.sv */
// Top level of the Gregorian day difference core.
//
//   port group | dir | tdata bits, low to high
//   s_*        | in  | first_year, first_month, first_day, second_year, second_month, second_day
//   m_*        | out | day_difference (23-bit two's complement)
//
// A word goes from acceptance to m_tvalid through four steps per date through the shared
// 1/25 reciprocal multiplier and adders, then one difference step that waits until the output register is free.
// One word is in flight at a time; s_tready is high only while the sequencer idles.
// A new word may be taken while the previous result waits in the output register.
// rst is synchronous and clears the sequencer and m_tvalid.
`default_nettype none

module days_between_dates_core
  import dbd_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  // first_year[13:0], first_month[17:14], first_day[22:18],
  // second_year[36:23], second_month[40:37], second_day[45:41], zero fill
  input  wire  [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  // day_difference[22:0], zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  dbd_cmd_t          cmd;
  logic [DIFF_W-1:0] day_difference;

  dbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  dbd_datapath u_datapath (
    .clk            (clk),
    .in_data        (s_tdata),
    .cmd            (cmd),
    .day_difference (day_difference)
  );

  assign m_tdata = {{(OUT_TDATA_W-DIFF_W){1'b0}}, day_difference};

  a_result_after_diff: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == OP_DIFF))
    else $error("result word raised without a difference step");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !s_tready)
    else $error("input still ready after a word was taken");

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (cmd.op == OP_NONE))
    else $error("datapath step issued while idle");

endmodule

`default_nettype wire
